### rtl/pcw_pkg.sv
// Shared types and constants for the PNG chunk walker.
// Depends on nothing; pcw_walker, pcw_rsp_stage and png_chunk_walker_core import it.
package pcw_pkg;

   typedef enum logic [2:0] {
      REGION_SIG   = 3'd0,
      REGION_LEN   = 3'd1,
      REGION_TYPE  = 3'd2,
      REGION_DATA  = 3'd3,
      REGION_CRC   = 3'd4,
      REGION_AFTER = 3'd5
   } region_type;

   typedef enum logic [1:0] {
      OUTCOME_CONT      = 2'd0,
      OUTCOME_TRUNC     = 2'd1,
      OUTCOME_PLAIN     = 2'd2,
      OUTCOME_TRAILING  = 2'd3
   } outcome_type;

   localparam logic [31:0] IEND_TYPE = 32'h49454E44;
   localparam logic [31:0] SAT32     = 32'hFFFFFFFF;

   typedef struct packed {
      logic [2:0]  region;
      logic        signature_bad;
      logic        image_end_here;
      logic [1:0]  outcome;
      logic [31:0] image_size;
   } result_type;

   function automatic logic [7:0] png_magic(input logic [2:0] idx);
      logic [7:0] value;
      unique case (idx)
         3'd0: value = 8'h89;
         3'd1: value = 8'h50;
         3'd2: value = 8'h4E;
         3'd3: value = 8'h47;
         3'd4: value = 8'h0D;
         3'd5: value = 8'h0A;
         3'd6: value = 8'h1A;
         default: value = 8'h0A;
      endcase
      return value;
   endfunction

endpackage

### rtl/pcw_req_if.sv
// Byte input channel of the PNG chunk walker: valid, ready and one file byte.
// Depends on nothing.
interface pcw_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

### rtl/pcw_rsp_if.sv
// Result channel of the PNG chunk walker: valid, ready and one result per byte.
// Depends on nothing.
interface pcw_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  region;
   logic        signature_bad;
   logic        image_end_here;
   logic [1:0]  outcome;
   logic [31:0] image_size;

   modport source (output valid, output region, output signature_bad,
                   output image_end_here, output outcome, output image_size,
                   input ready);
   modport sink (input valid, input region, input signature_bad,
                 input image_end_here, input outcome, input image_size,
                 output ready);
endinterface

### rtl/pcw_walker.sv
// Parser state of the PNG chunk walker and the per-byte result logic.
// Depends on pcw_pkg.
module pcw_walker
   import pcw_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic [7:0] data_byte,
   input  logic       last_byte,
   output result_type result
);

   region_type  phase_ff, phase_in;
   logic [2:0]  bif_ff, bif_in;
   logic [31:0] len_acc_ff, len_acc_in;
   logic [31:0] remain_ff, remain_in;
   logic [31:0] type_acc_ff, type_acc_in;
   logic        sig_bad_ff, sig_bad_in;
   logic [31:0] offset_ff, offset_in;
   logic        done_ff, done_in;
   logic        end_here;
   logic [31:0] remain_dec;

   assign remain_dec = remain_ff - 32'd1;

   always_comb begin
      phase_in    = phase_ff;
      bif_in      = bif_ff;
      len_acc_in  = len_acc_ff;
      remain_in   = remain_ff;
      type_acc_in = type_acc_ff;
      sig_bad_in  = sig_bad_ff;
      done_in     = done_ff;
      end_here    = 1'b0;
      offset_in   = offset_ff;
      if (!done_ff && offset_ff != SAT32) begin
         offset_in = offset_ff + 32'd1;
      end
      unique case (phase_ff)
         REGION_SIG: begin
            if (data_byte != png_magic(bif_ff)) begin
               sig_bad_in = 1'b1;
            end
            if (bif_ff == 3'd7) begin
               bif_in   = 3'd0;
               phase_in = REGION_LEN;
            end else begin
               bif_in = bif_ff + 3'd1;
            end
         end
         REGION_LEN: begin
            len_acc_in = {len_acc_ff[23:0], data_byte};
            if (bif_ff[1:0] == 2'd3) begin
               remain_in  = {len_acc_ff[23:0], data_byte};
               len_acc_in = '0;
               bif_in     = 3'd0;
               phase_in   = REGION_TYPE;
            end else begin
               bif_in = bif_ff + 3'd1;
            end
         end
         REGION_TYPE: begin
            type_acc_in = {type_acc_ff[23:0], data_byte};
            if (bif_ff[1:0] == 2'd3) begin
               bif_in   = 3'd0;
               phase_in = (remain_ff == '0) ? REGION_CRC : REGION_DATA;
            end else begin
               bif_in = bif_ff + 3'd1;
            end
         end
         REGION_DATA: begin
            remain_in = remain_dec;
            if (remain_dec == '0) begin
               bif_in   = 3'd0;
               phase_in = REGION_CRC;
            end
         end
         REGION_CRC: begin
            if (bif_ff[1:0] == 2'd3) begin
               bif_in = 3'd0;
               if (type_acc_ff == IEND_TYPE) begin
                  end_here = 1'b1;
                  done_in  = 1'b1;
                  phase_in = REGION_AFTER;
               end else begin
                  phase_in = REGION_LEN;
               end
               type_acc_in = '0;
            end else begin
               bif_in = bif_ff + 3'd1;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      result.region         = phase_ff;
      result.signature_bad  = sig_bad_in;
      result.image_end_here = end_here;
      result.image_size     = done_in ? offset_in : '0;
      if (!last_byte) begin
         result.outcome = OUTCOME_CONT;
      end else if (!done_in) begin
         result.outcome = OUTCOME_TRUNC;
      end else if (end_here) begin
         result.outcome = OUTCOME_PLAIN;
      end else begin
         result.outcome = OUTCOME_TRAILING;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (accept && last_byte)) begin
         phase_ff    <= REGION_SIG;
         bif_ff      <= '0;
         len_acc_ff  <= '0;
         remain_ff   <= '0;
         type_acc_ff <= '0;
         sig_bad_ff  <= 1'b0;
         offset_ff   <= '0;
         done_ff     <= 1'b0;
      end else if (accept) begin
         phase_ff    <= phase_in;
         bif_ff      <= bif_in;
         len_acc_ff  <= len_acc_in;
         remain_ff   <= remain_in;
         type_acc_ff <= type_acc_in;
         sig_bad_ff  <= sig_bad_in;
         offset_ff   <= offset_in;
         done_ff     <= done_in;
      end
   end

endmodule

### rtl/pcw_rsp_stage.sv
// Result register of the PNG chunk walker; holds one result until transferred.
// Depends on pcw_pkg and pcw_rsp_if.
module pcw_rsp_stage
   import pcw_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   input  result_type in_result,
   pcw_rsp_if.source  rsp_ch
);

   logic       valid_ff;
   result_type result_ff;

   assign in_ready = !valid_ff || rsp_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         result_ff <= in_result;
      end
   end

   assign rsp_ch.valid          = valid_ff;
   assign rsp_ch.region         = result_ff.region;
   assign rsp_ch.signature_bad  = result_ff.signature_bad;
   assign rsp_ch.image_end_here = result_ff.image_end_here;
   assign rsp_ch.outcome        = result_ff.outcome;
   assign rsp_ch.image_size     = result_ff.image_size;

endmodule

### rtl/png_chunk_walker_core.sv
// Top level of the PNG chunk walker: parser state plus a result register.
// Depends on pcw_pkg, pcw_req_if, pcw_rsp_if, pcw_walker and pcw_rsp_stage.
//
// The block takes a file one byte per transfer on req_ch and returns exactly
// one result per byte on rsp_ch. A result gives the byte's region, the sticky
// signature mismatch flag, whether the byte closes the IEND chunk, how the
// file ended when the byte carries last_byte, and the image size once IEND
// has ended. After a last byte the parser starts over on a fresh file.
// The result of a byte is registered and valid in the cycle after its
// transfer. Throughput is one byte per cycle while the receiver takes
// results, set by the single result register, which takes a new result in
// the same cycle the old one leaves. When the receiver stalls, req_ch.ready
// drops while the result register is full and rsp_ch.ready is low, and the
// held result stays stable. Synchronous reset returns the parser to the
// start of the signature and empties the result register.
module png_chunk_walker_core
   import pcw_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   pcw_req_if.sink   req_ch,
   pcw_rsp_if.source rsp_ch
);

   logic       accept;
   logic       stage_ready;
   result_type result;

   assign req_ch.ready = stage_ready;
   assign accept       = req_ch.valid && stage_ready;

   pcw_walker u_walker (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .data_byte (req_ch.data_byte),
      .last_byte (req_ch.last_byte),
      .result    (result)
   );

   pcw_rsp_stage u_rsp_stage (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_ch.valid),
      .in_ready  (stage_ready),
      .in_result (result),
      .rsp_ch    (rsp_ch)
   );

endmodule
